// ----- rtl/core/ias_word_pair_executor_macros.svh -----
// Assertion helpers for the word pair executor RTL, included by iaswpe_ctrl.
`ifndef IAS_WORD_PAIR_EXECUTOR_MACROS_SVH
`define IAS_WORD_PAIR_EXECUTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IASWPE_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IASWPE_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/iaswpe_pkg.sv -----
`timescale 1ns / 1ps

package iaswpe_pkg;

  localparam logic [1:0] MODE_EXEC  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [7:0] OPC_LOAD = 8'h01;
  localparam logic [7:0] OPC_STOR = 8'h21;
  localparam logic [7:0] OPC_ADD  = 8'h05;

  localparam logic [11:0] PC_START = 12'd420;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EX_L,
    S_RD_R,
    S_EX_R,
    S_HOST_WR,
    S_HOST_RD,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    RD_SRC_LEFT,
    RD_SRC_HOST,
    RD_SRC_RIGHT
  } rd_src_t;

  typedef struct packed {
    logic    load_in;
    logic    clr_we;
    rd_src_t rd_src;
    logic    exec_left;
    logic    exec_right;
    logic    pc_step;
    logic    host_wr;
    logic    cap_read;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_sts_t;

endpackage

// ----- rtl/core/ias_word_pair_executor.sv -----
`timescale 1ns / 1ps

// Channel   | Ports                                       | Transfer
// ----------+---------------------------------------------+---------------------------
// command   | mode, instr_word, mem_addr, mem_data        | start high, busy low
// result    | acc, buffer_reg, prog_count, read_data      | done high, one cycle
//
// An execute item passes through S_EX_L, S_RD_R and S_EX_R to S_OUT, where done
// is high and a new command may transfer. The sequence is set by two dependent
// read and write-back passes through the single synchronous data memory. Write
// and read items pass through S_HOST_WR or S_HOST_RD to S_OUT; mode 3 goes
// straight to S_OUT. After reset the memory is cleared one word a cycle, all
// MEM_WORDS words, with busy held high. The result side cannot stall.

module ias_word_pair_executor #(
  parameter int MEM_WORDS = 4096,
  parameter int WORD_BITS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic [39:0]        instr_word,
  input  logic [11:0]        mem_addr,
  input  logic signed [63:0] mem_data,
  output logic               done,
  output logic signed [63:0] acc,
  output logic signed [63:0] buffer_reg,
  output logic [11:0]        prog_count,
  output logic signed [63:0] read_data
);

  iaswpe_pkg::dp_cmd_t cmd;
  iaswpe_pkg::dp_sts_t sts;

  iaswpe_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .mode (mode),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy),
    .done (done)
  );

  iaswpe_dp #(
    .MEM_WORDS(MEM_WORDS),
    .WORD_BITS(WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .instr_word(instr_word),
    .mem_addr  (mem_addr),
    .mem_data  (mem_data),
    .acc       (acc),
    .buffer_reg(buffer_reg),
    .prog_count(prog_count),
    .read_data (read_data)
  );

endmodule

// ----- rtl/core/iaswpe_ram.sv -----
`timescale 1ns / 1ps

module iaswpe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/iaswpe_ctrl.sv -----
`timescale 1ns / 1ps
`include "ias_word_pair_executor_macros.svh"

module iaswpe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          mode,
  input  iaswpe_pkg::dp_sts_t sts,
  output iaswpe_pkg::dp_cmd_t cmd,
  output logic                busy,
  output logic                done
);

  iaswpe_pkg::state_t state;
  iaswpe_pkg::state_t state_next;
  logic               accept;

  // A new item may enter while the previous result is on the strobe.
  assign accept = start && ((state == iaswpe_pkg::S_IDLE) || (state == iaswpe_pkg::S_OUT));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iaswpe_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      iaswpe_pkg::S_CLEAR: begin
        if (sts.clr_last) begin
          state_next = iaswpe_pkg::S_IDLE;
        end
      end
      iaswpe_pkg::S_IDLE, iaswpe_pkg::S_OUT: begin
        if (accept) begin
          case (mode)
            iaswpe_pkg::MODE_EXEC:  state_next = iaswpe_pkg::S_EX_L;
            iaswpe_pkg::MODE_WRITE: state_next = iaswpe_pkg::S_HOST_WR;
            iaswpe_pkg::MODE_READ:  state_next = iaswpe_pkg::S_HOST_RD;
            default:                state_next = iaswpe_pkg::S_OUT;
          endcase
        end else begin
          state_next = iaswpe_pkg::S_IDLE;
        end
      end
      iaswpe_pkg::S_EX_L:    state_next = iaswpe_pkg::S_RD_R;
      iaswpe_pkg::S_RD_R:    state_next = iaswpe_pkg::S_EX_R;
      iaswpe_pkg::S_EX_R:    state_next = iaswpe_pkg::S_OUT;
      iaswpe_pkg::S_HOST_WR: state_next = iaswpe_pkg::S_OUT;
      iaswpe_pkg::S_HOST_RD: state_next = iaswpe_pkg::S_OUT;
      default:               state_next = iaswpe_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.rd_src     = iaswpe_pkg::RD_SRC_LEFT;
    busy           = 1'b1;
    done           = 1'b0;
    case (state)
      iaswpe_pkg::S_CLEAR: begin
        cmd.clr_we = 1'b1;
      end
      iaswpe_pkg::S_IDLE, iaswpe_pkg::S_OUT: begin
        busy        = 1'b0;
        done        = (state == iaswpe_pkg::S_OUT);
        cmd.load_in = accept;
        // The first memory read is issued straight from the input ports.
        cmd.rd_src  = (mode == iaswpe_pkg::MODE_READ) ? iaswpe_pkg::RD_SRC_HOST
                                                       : iaswpe_pkg::RD_SRC_LEFT;
      end
      iaswpe_pkg::S_EX_L: begin
        cmd.exec_left = 1'b1;
        cmd.pc_step   = 1'b1;
      end
      iaswpe_pkg::S_RD_R: begin
        cmd.rd_src = iaswpe_pkg::RD_SRC_RIGHT;
      end
      iaswpe_pkg::S_EX_R: begin
        cmd.exec_right = 1'b1;
      end
      iaswpe_pkg::S_HOST_WR: begin
        cmd.host_wr = 1'b1;
      end
      iaswpe_pkg::S_HOST_RD: begin
        cmd.cap_read = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  `IASWPE_ASSERT_NEXT(a_exec_enters_left, clk, rst,
    accept && (mode == iaswpe_pkg::MODE_EXEC), state == iaswpe_pkg::S_EX_L,
    "execute item did not start with the left instruction")
  `IASWPE_ASSERT_NEXT(a_right_after_left, clk, rst,
    state == iaswpe_pkg::S_EX_L, cmd.rd_src == iaswpe_pkg::RD_SRC_RIGHT,
    "right instruction read did not follow the left instruction")
  `IASWPE_ASSERT_NEXT(a_result_after_right, clk, rst,
    state == iaswpe_pkg::S_EX_R, done && !busy,
    "no result strobe after the right instruction")
  `IASWPE_ASSERT_NEXT(a_host_write_issued, clk, rst,
    accept && (mode == iaswpe_pkg::MODE_WRITE), cmd.host_wr,
    "memory write item did not write")

endmodule

// ----- rtl/core/iaswpe_dp.sv -----
`timescale 1ns / 1ps

module iaswpe_dp #(
  parameter int MEM_WORDS = 4096,
  parameter int WORD_BITS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  iaswpe_pkg::dp_cmd_t cmd,
  output iaswpe_pkg::dp_sts_t sts,
  input  logic [39:0]         instr_word,
  input  logic [11:0]         mem_addr,
  input  logic signed [63:0]  mem_data,
  output logic signed [63:0]  acc,
  output logic signed [63:0]  buffer_reg,
  output logic [11:0]         prog_count,
  output logic signed [63:0]  read_data
);

  localparam int AW = $clog2(MEM_WORDS);

  // Reduce a 12-bit address modulo MEM_WORDS by restoring subtraction.
  // The quotient is below 256 when MEM_WORDS is at least 16, so eight steps cover it.
  function automatic logic [AW-1:0] mem_index(input logic [11:0] a);
    logic [19:0] v;
    v = {8'd0, a};
    for (int k = 7; k >= 0; k--) begin
      if (v >= (20'(MEM_WORDS) << k)) begin
        v = v - (20'(MEM_WORDS) << k);
      end
    end
    return v[AW-1:0];
  endfunction

  logic signed [WORD_BITS-1:0] accum;
  logic signed [WORD_BITS-1:0] accum_next;
  logic signed [WORD_BITS-1:0] membuf;
  logic signed [WORD_BITS-1:0] membuf_next;
  logic [11:0]                 pc;
  logic signed [63:0]          read_word;
  logic [AW-1:0]               clr_addr;

  logic [7:0]           op_l;
  logic [7:0]           op_r;
  logic [AW-1:0]        idx_l;
  logic [AW-1:0]        idx_r;
  logic [AW-1:0]        host_idx;
  logic [WORD_BITS-1:0] host_data;

  logic [AW-1:0] port_idx_l;
  logic [AW-1:0] port_idx_r;
  logic [AW-1:0] port_idx_host;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [WORD_BITS-1:0]        ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [WORD_BITS-1:0]        ram_rdata;
  logic signed [WORD_BITS-1:0] rd_word;

  logic          exec;
  logic [7:0]    op;
  logic [AW-1:0] idx;
  logic          stor_we;

  assign port_idx_l    = mem_index(instr_word[31:20]);
  assign port_idx_r    = mem_index(instr_word[11:0]);
  assign port_idx_host = mem_index(mem_addr);

  assign rd_word = ram_rdata;
  assign exec    = cmd.exec_left || cmd.exec_right;
  assign op      = cmd.exec_right ? op_r : op_l;
  assign idx     = cmd.exec_right ? idx_r : idx_l;

  always_comb begin
    accum_next  = accum;
    membuf_next = membuf;
    stor_we     = 1'b0;
    if (exec) begin
      case (op)
        iaswpe_pkg::OPC_LOAD: begin
          accum_next  = rd_word;
          membuf_next = rd_word;
        end
        iaswpe_pkg::OPC_STOR: begin
          stor_we     = 1'b1;
          membuf_next = accum;
        end
        iaswpe_pkg::OPC_ADD: begin
          accum_next  = accum + rd_word;
          membuf_next = rd_word;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    ram_we    = cmd.clr_we || cmd.host_wr || stor_we;
    ram_waddr = idx;
    ram_wdata = accum;
    if (cmd.clr_we) begin
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (cmd.host_wr) begin
      ram_waddr = host_idx;
      ram_wdata = host_data;
    end
  end

  always_comb begin
    case (cmd.rd_src)
      iaswpe_pkg::RD_SRC_LEFT:  ram_raddr = port_idx_l;
      iaswpe_pkg::RD_SRC_HOST:  ram_raddr = port_idx_host;
      iaswpe_pkg::RD_SRC_RIGHT: ram_raddr = idx_r;
      default:                  ram_raddr = port_idx_l;
    endcase
  end

  iaswpe_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MEM_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      accum    <= '0;
      membuf   <= '0;
      pc       <= iaswpe_pkg::PC_START;
      clr_addr <= '0;
    end else begin
      accum  <= accum_next;
      membuf <= membuf_next;
      if (cmd.pc_step) begin
        pc <= pc + 12'd1;
      end
      if (cmd.clr_we) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_l      <= instr_word[39:32];
      op_r      <= instr_word[19:12];
      idx_l     <= port_idx_l;
      idx_r     <= port_idx_r;
      host_idx  <= port_idx_host;
      host_data <= mem_data[WORD_BITS-1:0];
      read_word <= '0;
    end else if (cmd.cap_read) begin
      read_word <= 64'(rd_word);
    end
  end

  assign sts.clr_last = (clr_addr == AW'(MEM_WORDS - 1));

  assign acc        = 64'(accum);
  assign buffer_reg = 64'(membuf);
  assign prog_count = pc;
  assign read_data  = read_word;

endmodule
